### src/assert_macros.svh
// Assertion macros shared by the reorder RTL.
// Plain text only; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/b2y_pkg.sv
// Package for the block-to-YUY2 reorder: fixed field widths, register
// indexes, reset values and the pending-item record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2y_pkg;

    // Fixed field widths.
    localparam int ADDR_W      = 22;
    localparam int DATA_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int BPR_W       = 7;
    localparam int ROWS_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Bytes in one 16x8 block: two luma halves, then U, then V.
    localparam logic [OFFSET_W-1:0] BLOCK_BYTES = 8'd192;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ROW_BLOCKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BLOCK_ROWS = 2'd1;

    // Register reset values.
    localparam logic [BPR_W-1:0]  BPR_RESET  = 7'd40;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 8'd60;

    // One accepted item with both of its possible write addresses.
    typedef struct packed {
        logic [ADDR_W-1:0] addr_first;
        logic [ADDR_W-1:0] addr_second;
        logic [DATA_W-1:0] data;
        logic              dual;
    } pend_item_t;

endpackage

`default_nettype wire

### src/block_to_yuy2_reorder.sv
// Block-to-YUY2 reorder top level: counters, address generation, a pending
// item register and the result register. Uses b2y_pkg and assert_macros.svh.
//
// Usage:
// - Input channel (s_valid/s_ready): one raw byte per item, with s_frame_start
//   marking the first byte of a frame, which restarts the block counters.
// - Result channel (m_valid/m_ready): frame byte address and byte value. A luma
//   byte gives one result, a chroma byte two results on adjacent lines;
//   m_last_of_run marks the final result of each input item.
// - Config channel (cfg_valid/cfg_ready): index 0 is the row width in blocks,
//   index 1 is block_rows. Writes are always taken; other indexes are ignored.
// - Path: an accepted item waits in the pending register, and its first result
//   moves from there into the result register when that register is free.
// - Throughput: one luma item per cycle while m_ready stays high; a chroma item
//   keeps s_ready low until the single result port takes its second result.
// - Reset: counters and frame base clear, registers return to 40 and 60 and
//   both the pending and result registers empty.
// - Stall: when m_ready is low, one result waits on m_* and one item waits
//   in the pending register; s_ready then drops until that item drains.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_to_yuy2_reorder #(
    parameter int MAX_ROW_BLOCKS = 80,
    parameter int MAX_BLOCK_ROWS = 128
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input items
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [b2y_pkg::DATA_W-1:0]       s_data_byte,
    input  wire logic                             s_frame_start,
    // Result items
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [b2y_pkg::ADDR_W-1:0]            m_write_address,
    output logic [b2y_pkg::DATA_W-1:0]            m_write_byte,
    output logic                                  m_last_of_run,
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [b2y_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [b2y_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W  = (MAX_ROW_BLOCKS > 1) ? $clog2(MAX_ROW_BLOCKS) : 1;
    localparam int ROW_W  = (MAX_BLOCK_ROWS > 1) ? $clog2(MAX_BLOCK_ROWS) : 1;
    localparam int EFF_W  = $clog2(MAX_ROW_BLOCKS + 1);
    localparam int REFF_W = $clog2(MAX_BLOCK_ROWS + 1);
    localparam int PITCH_W = EFF_W + 5;
    localparam int LOFF_W  = PITCH_W + 4;
    localparam int RP_W    = ROW_W + EFF_W;
    localparam int AW      = b2y_pkg::ADDR_W;

    // Configuration registers
    logic [b2y_pkg::BPR_W-1:0]  bpr_reg;
    logic [b2y_pkg::ROWS_W-1:0] rows_reg;

    // Block position state
    logic [b2y_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [AW-1:0]                base_reg, base_next;

    // Pending item and result registers
    b2y_pkg::pend_item_t          pend_reg, pend_next;
    logic                         pend_valid_reg;
    logic                         pend_phase_reg;
    logic                         m_valid_reg;
    logic [AW-1:0]                m_addr_reg;
    logic [b2y_pkg::DATA_W-1:0]   m_byte_reg;
    logic                         m_last_reg;

    // Current position, after a frame start restart
    logic [b2y_pkg::OFFSET_W-1:0] offset_cur;
    logic [COL_W-1:0]             col_cur;
    logic [ROW_W-1:0]             row_cur;
    logic [AW-1:0]                base_cur;

    logic [EFF_W-1:0]   eff_bpr;
    logic [REFF_W-1:0]  eff_rows;
    logic [PITCH_W-1:0] pitch;
    logic               is_luma;
    logic [2:0]         line_sel;
    logic [3:0]         line_below;
    logic [4:0]         col_byte;
    logic [LOFF_W-1:0]  line_off_first, line_off_second;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [RP_W-1:0]    row_prod;

    logic out_load, pend_take, pend_done, in_acc;

    // Configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpr_reg  <= b2y_pkg::BPR_RESET;
            rows_reg <= b2y_pkg::ROWS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                b2y_pkg::CFG_IDX_ROW_BLOCKS: bpr_reg  <= cfg_data[b2y_pkg::BPR_W-1:0];
                b2y_pkg::CFG_IDX_BLOCK_ROWS: rows_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the registers to 1..MAX.
    always_comb begin
        if (bpr_reg == '0) begin
            eff_bpr = EFF_W'(1);
        end else if (32'(bpr_reg) > 32'(MAX_ROW_BLOCKS)) begin
            eff_bpr = EFF_W'(MAX_ROW_BLOCKS);
        end else begin
            eff_bpr = EFF_W'(bpr_reg);
        end
        if (rows_reg == '0) begin
            eff_rows = REFF_W'(1);
        end else if (32'(rows_reg) > 32'(MAX_BLOCK_ROWS)) begin
            eff_rows = REFF_W'(MAX_BLOCK_ROWS);
        end else begin
            eff_rows = REFF_W'(rows_reg);
        end
    end

    assign pitch = {eff_bpr, 5'b0};

    // A frame start places this byte at offset 0 of the first block.
    assign offset_cur = s_frame_start ? '0 : offset_reg;
    assign col_cur    = s_frame_start ? '0 : col_reg;
    assign row_cur    = s_frame_start ? '0 : row_reg;
    assign base_cur   = s_frame_start ? '0 : base_reg;

    // Decode the offset into a line and a byte column inside the block.
    // Luma goes to even bytes; U to byte 1 and V to byte 3 of each group of four.
    always_comb begin
        is_luma = !offset_cur[7];
        if (is_luma) begin
            line_sel = offset_cur[5:3];
            col_byte = {offset_cur[6], offset_cur[2:0], 1'b0};
        end else begin
            line_sel = {offset_cur[4:3], 1'b0};
            col_byte = {offset_cur[2:0], offset_cur[5], 1'b1};
        end
        line_below = {1'b0, line_sel} + 4'd1;
        line_off_first  = LOFF_W'(line_sel) * LOFF_W'(pitch);
        line_off_second = LOFF_W'(line_below) * LOFF_W'(pitch);
    end

    // Item record for the pending register.
    always_comb begin
        pend_next.addr_first  = base_cur + AW'(line_off_first) + AW'(col_byte);
        pend_next.addr_second = base_cur + AW'(line_off_second) + AW'(col_byte);
        pend_next.data        = s_data_byte;
        pend_next.dual        = !is_luma;
    end

    // Advance the block position; the new base uses the current pitch.
    always_comb begin
        offset_next = offset_cur + 8'd1;
        col_next    = col_cur;
        row_next    = row_cur;
        col_inc     = (COL_W+1)'(col_cur) + (COL_W+1)'(1);
        row_inc     = (ROW_W+1)'(row_cur) + (ROW_W+1)'(1);
        if (offset_next >= b2y_pkg::BLOCK_BYTES) begin
            offset_next = '0;
            if (32'(col_inc) >= 32'(eff_bpr)) begin
                col_next = '0;
                if (32'(row_inc) >= 32'(eff_rows)) begin
                    row_next = '0;
                end else begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        row_prod  = RP_W'(row_next) * RP_W'(eff_bpr);
        base_next = AW'({row_prod, 8'b0}) + AW'({col_next, 5'b0});
        if (offset_next != '0) begin
            base_next = base_cur;
        end
    end

    // Handshake: the pending item frees when its last result moves out.
    assign out_load  = !m_valid_reg || m_ready;
    assign pend_take = pend_valid_reg && out_load;
    assign pend_done = pend_take && (!pend_reg.dual || pend_phase_reg);
    assign s_ready   = !pend_valid_reg || pend_done;
    assign in_acc    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
        end else if (in_acc) begin
            offset_reg <= offset_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
        end
    end

    // Pending item register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_phase_reg <= 1'b0;
        end else if (in_acc) begin
            pend_valid_reg <= 1'b1;
            pend_phase_reg <= 1'b0;
        end else if (pend_done) begin
            pend_valid_reg <= 1'b0;
            pend_phase_reg <= 1'b0;
        end else if (pend_take) begin
            pend_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pend_reg <= pend_next;
        end
    end

    // Result register: first address, then the line below for chroma.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= pend_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_take) begin
            m_addr_reg <= pend_phase_reg ? pend_reg.addr_second : pend_reg.addr_first;
            m_byte_reg <= pend_reg.data;
            m_last_reg <= !pend_reg.dual || pend_phase_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = m_addr_reg;
    assign m_write_byte    = m_byte_reg;
    assign m_last_of_run   = m_last_reg;

    // Checks on the block position and the two-result sequence.
    `ASSERT_CLK(a_offset_range, aclk, aresetn,
        offset_reg < b2y_pkg::BLOCK_BYTES, "block offset out of range")
    `ASSERT_CLK(a_col_range, aclk, aresetn,
        32'(col_reg) < 32'(MAX_ROW_BLOCKS), "block column out of range")
    `ASSERT_NEXT(a_second_follows, aclk, aresetn,
        m_valid && m_ready && !m_last_of_run, m_valid && m_last_of_run,
        "second chroma write did not follow")
    `ASSERT_IMPL(a_phase_dual, aclk, aresetn,
        pend_phase_reg, pend_valid_reg && pend_reg.dual,
        "second-half phase without a chroma item")

endmodule

`default_nettype wire

### tb/yuy2_write_checker.sv
// Checker for the block-to-YUY2 reorder: watches the input, result and register channels,
// predicts every frame write from the accepted bytes and compares the results in order.
// Depends on b2y_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module yuy2_write_checker #(
    parameter int MAX_ROW_BLOCKS = 80,
    parameter int MAX_BLOCK_ROWS = 128
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    input  logic                                      s_ready,
    input  logic [b2y_pkg::DATA_W-1:0]                s_data_byte,
    input  logic                                      s_frame_start,
    input  logic                                      m_valid,
    input  logic                                      m_ready,
    input  logic [b2y_pkg::ADDR_W-1:0]                m_write_address,
    input  logic [b2y_pkg::DATA_W-1:0]                m_write_byte,
    input  logic                                      m_last_of_run,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [b2y_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [b2y_pkg::CFG_DATA_W-1:0]            cfg_data,
    output int                                        outstanding,
    output int                                        mismatch_count
);

    // Layout of one 192-byte block.
    localparam int RIGHT_LUMA_START = 64;
    localparam int U_START          = 128;
    localparam int V_START          = 160;
    localparam int LINES_PER_BLOCK  = 8;
    localparam int BLOCK_SPAN_BYTES = 32;
    localparam int REPORT_LIMIT     = 10;
    localparam int AW               = b2y_pkg::ADDR_W;
    localparam int OW               = b2y_pkg::OFFSET_W;

    typedef struct packed {
        logic [b2y_pkg::ADDR_W-1:0] addr;
        logic [b2y_pkg::DATA_W-1:0] value;
        logic                       is_last;
    } frame_write_t;

    // Register copies and the block position in the frame.
    logic [b2y_pkg::BPR_W-1:0]    reg_bpr;
    logic [b2y_pkg::ROWS_W-1:0]   reg_rows;
    logic [b2y_pkg::OFFSET_W-1:0] offset;
    logic [6:0]                   column;
    logic [6:0]                   row;
    logic [b2y_pkg::ADDR_W-1:0]   base;

    // Frame writes still to come from the block, oldest first.
    frame_write_t pending_writes[$];

    // Register values as the block uses them: zero acts as one, large values clamp.
    function automatic int eff_bpr();
        int v;
        v = reg_bpr;
        if (v == 0) v = 1;
        if (v > MAX_ROW_BLOCKS) v = MAX_ROW_BLOCKS;
        return v;
    endfunction

    function automatic int eff_rows();
        int v;
        v = reg_rows;
        if (v == 0) v = 1;
        if (v > MAX_BLOCK_ROWS) v = MAX_BLOCK_ROWS;
        return v;
    endfunction

    // Place one input byte in the frame and advance the block counters.
    task automatic place_byte(input logic [b2y_pkg::DATA_W-1:0] value,
                              input logic frame_start);
        int pitch, off, r, line, col, b;
        frame_write_t w;
        pitch = eff_bpr() * BLOCK_SPAN_BYTES;
        if (frame_start) begin
            offset = '0;
            column = '0;
            row    = '0;
            base   = '0;
        end
        off = offset;
        b   = base;
        w.value = value;
        if (off < U_START) begin
            // Luma: one write, left half in columns 0..15, right half in 16..31.
            r    = (off < RIGHT_LUMA_START) ? off : off - RIGHT_LUMA_START;
            line = r / 8;
            col  = (r % 8) * 2 + ((off < RIGHT_LUMA_START) ? 0 : 16);
            w.addr    = AW'(b + line * pitch + col);
            w.is_last = 1'b1;
            pending_writes.push_back(w);
        end else begin
            // Chroma: the same sample goes to two adjacent lines.
            r    = (off < V_START) ? off - U_START : off - V_START;
            line = (r / 8) * 2;
            col  = (r % 8) * 4 + ((off < V_START) ? 1 : 3);
            w.addr    = AW'(b + line * pitch + col);
            w.is_last = 1'b0;
            pending_writes.push_back(w);
            w.addr    = AW'(b + (line + 1) * pitch + col);
            w.is_last = 1'b1;
            pending_writes.push_back(w);
        end
        if (off + 1 >= int'(b2y_pkg::BLOCK_BYTES)) begin
            offset = '0;
            if (int'(column) + 1 >= eff_bpr()) begin
                column = '0;
                if (int'(row) + 1 >= eff_rows()) row = '0;
                else row = row + 7'd1;
            end else begin
                column = column + 7'd1;
            end
            base = AW'(int'(row) * LINES_PER_BLOCK * pitch
                       + int'(column) * BLOCK_SPAN_BYTES);
        end else begin
            offset = OW'(off + 1);
        end
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin : watch
        frame_write_t got, want;
        if (!aresetn) begin
            reg_bpr  = b2y_pkg::BPR_RESET;
            reg_rows = b2y_pkg::ROWS_RESET;
            offset   = '0;
            column   = '0;
            row      = '0;
            base     = '0;
            pending_writes.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    b2y_pkg::CFG_IDX_ROW_BLOCKS: reg_bpr  = cfg_data[b2y_pkg::BPR_W-1:0];
                    b2y_pkg::CFG_IDX_BLOCK_ROWS: reg_rows = cfg_data[b2y_pkg::ROWS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) place_byte(s_data_byte, s_frame_start);
            if (m_valid && m_ready) begin
                got = '{m_write_address, m_write_byte, m_last_of_run};
                if (pending_writes.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected write addr=%0h byte=%0h last=%0b",
                                 $realtime, got.addr, got.value, got.is_last);
                    mismatch_count++;
                end else begin
                    want = pending_writes.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"%0t: write mismatch: expected addr=%0h byte=%0h ",
                                      "last=%0b, got addr=%0h byte=%0h last=%0b"},
                                     $realtime, want.addr, want.value, want.is_last,
                                     got.addr, got.value, got.is_last);
                        mismatch_count++;
                    end
                end
            end
        end
        outstanding = pending_writes.size();
    end

endmodule

### tb/block_to_yuy2_reorder_test.sv
// Top of the block-to-YUY2 reorder test: clock, reset, register writes and byte stimulus.
// Instantiates block_to_yuy2_reorder and yuy2_write_checker; uses b2y_pkg.
`timescale 1ns / 1ps

module block_to_yuy2_reorder_test;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 8;
    localparam logic [63:0] EXTREME_BYTES = 64'h00FF807F01FEAA55;
    localparam int DW          = b2y_pkg::DATA_W;
    localparam int CW          = b2y_pkg::CFG_DATA_W;

    // Indexes that name no register; writes to them must change nothing.
    localparam logic [b2y_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [b2y_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_valid       = 1'b0;
    logic [b2y_pkg::DATA_W-1:0]      s_data_byte   = '0;
    logic                            s_frame_start = 1'b0;
    logic                            m_ready       = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic [b2y_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [b2y_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    logic                            s_ready;
    logic                            m_valid;
    logic [b2y_pkg::ADDR_W-1:0]      m_write_address;
    logic [b2y_pkg::DATA_W-1:0]      m_write_byte;
    logic                            m_last_of_run;
    logic                            cfg_ready;

    int outstanding;
    int mismatch_count;
    int quiet_cycles = 0;
    bit allow_idle   = 1'b1;
    bit hold_request = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    block_to_yuy2_reorder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_byte    (m_write_byte),
        .m_last_of_run   (m_last_of_run),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    yuy2_write_checker write_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_frame_start   (s_frame_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_byte    (m_write_byte),
        .m_last_of_run   (m_last_of_run),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .outstanding     (outstanding),
        .mismatch_count  (mismatch_count)
    );

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one byte, sometimes after an idle gap, and wait until it is taken.
    task automatic offer_byte(input logic [b2y_pkg::DATA_W-1:0] value,
                              input logic frame_start);
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= value;
        s_frame_start <= frame_start;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Register write; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [b2y_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [b2y_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge aclk);
    endtask

    // One setting of the frame size, a write to a spare index, then a stream of random bytes.
    task automatic run_phase(input logic [b2y_pkg::CFG_DATA_W-1:0] bpr,
                             input logic [b2y_pkg::CFG_DATA_W-1:0] rows,
                             input int count, input bit fresh_frame, input bit squeeze);
        bit fs;
        if ($urandom_range(0, 1) == 0) begin
            write_reg(b2y_pkg::CFG_IDX_ROW_BLOCKS, bpr);
            write_reg(b2y_pkg::CFG_IDX_BLOCK_ROWS, rows);
        end else begin
            write_reg(b2y_pkg::CFG_IDX_BLOCK_ROWS, rows);
            write_reg(b2y_pkg::CFG_IDX_ROW_BLOCKS, bpr);
        end
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  CW'($urandom));
        cfg_valid <= 1'b0;
        for (int i = 0; i < count; i++) begin
            fs = (fresh_frame && i == 0) || ($urandom_range(0, 299) == 0);
            if (squeeze && i == count / 4) hold_request = 1'b1;
            offer_byte(DW'($urandom), fs);
        end
        s_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extreme byte values and frame starts, including back to back.
        for (int i = 0; i < 20; i++)
            offer_byte(EXTREME_BYTES[8 * (i % 8) +: 8], (i == 0 || i == 9 || i == 10 || i == 17));
        s_valid <= 1'b0;
        wait_drained();

        // Smallest frame, wrapping without a frame start; then zero and
        // out-of-range register values; the largest frame under a long stall.
        run_phase(8'd1, 8'd1, 400, 1'b1, 1'b0);
        run_phase(8'h80, 8'd0, 200, 1'b0, 1'b0);
        run_phase(8'hFF, 8'hFF, 250, 1'b1, 1'b1);
        run_phase(8'd80, 8'd128, 150, 1'b0, 1'b0);
        run_phase(8'd4, 8'd3, 380, 1'b1, 1'b0);
        // Shrink the row mid-frame so a column already past the limit wraps.
        run_phase(8'd1, 8'd2, 150, 1'b0, 1'b0);
        // Closing stretch at full rate on both sides.
        allow_idle = 1'b0;
        run_phase(8'd3, 8'd2, 300, 1'b1, 1'b0);

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
